// File: design/assert_macros.svh
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/uapra_pkg.sv
package uapra_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PTR_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int WIN_DEPTH     = 11;
  localparam int PAT_COUNT     = 5;
  localparam int PAT_SPAN      = WIN_DEPTH + 1;

  localparam logic [7:0]  THRESH_RST   = 8'd3;
  localparam logic [15:0] RST_SECS_RST = 16'd60;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;

  typedef enum logic [0:0] {
    REG_THRESHOLD  = 1'b0,
    REG_RESET_SECS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_QUOTE_OR = 3'd0,
    KIND_SCRIPT   = 3'd1,
    KIND_DOTDOT   = 3'd2,
    KIND_SEMI     = 3'd3,
    KIND_UNION    = 3'd4,
    KIND_NONE     = 3'd5
  } kind_t;

  typedef logic [8*PAT_SPAN-1:0] pat_text_t;

  localparam pat_text_t PAT_TEXT [PAT_COUNT] = '{
    pat_text_t'("' OR '1'='1"),
    pat_text_t'("<script>"),
    pat_text_t'("../"),
    pat_text_t'(";"),
    pat_text_t'("UNION SELECT")
  };
  localparam int PAT_LEN [PAT_COUNT] = '{11, 8, 3, 1, 12};

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [31:0] now;
    logic [7:0]  thresh;
    logic [15:0] rst_secs;
  } ent_req_t;

  typedef struct packed {
    logic any_hit;
    logic any_free;
    logic repl;
  } ent_ctl_t;

  typedef struct packed {
    logic       alert;
    logic [7:0] count;
  } ent_res_t;

  // bytes oldest first: byte 0 .. byte PAT_SPAN-1, the last one current
  function automatic logic [PAT_COUNT-1:0] pattern_hits(
    input logic [8*PAT_SPAN-1:0] bytes
  );
    logic [PAT_COUNT-1:0] m;
    m = '1;
    for (int p = 0; p < PAT_COUNT; p++) begin
      for (int k = 0; k < PAT_SPAN; k++) begin
        if (k >= PAT_SPAN - PAT_LEN[p]) begin
          if (bytes[8*k +: 8] != PAT_TEXT[p][8*(PAT_SPAN-1-k) +: 8]) begin
            m[p] = 1'b0;
          end
        end
      end
    end
    return m;
  endfunction

endpackage

// File: design/uapra_matcher.sv
module uapra_matcher import uapra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] uri_byte,
  input  logic       last_byte,
  output kind_t      kind
);

  logic [7:0]           win_r [WIN_DEPTH];
  logic [7:0]           win_nxt [WIN_DEPTH];
  logic [PAT_COUNT-1:0] mask_r, mask_nxt, mask_all;
  logic [8*PAT_SPAN-1:0] span;

  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      span[8*k +: 8] = win_r[k];
    end
    span[8*WIN_DEPTH +: 8] = uri_byte;
    mask_all = mask_r | pattern_hits(span);
    kind = KIND_NONE;
    for (int p = PAT_COUNT - 1; p >= 0; p--) begin
      if (mask_all[p]) begin
        kind = kind_t'(p[2:0]);
      end
    end
  end

  always_comb begin
    win_nxt  = win_r;
    mask_nxt = mask_r;
    if (take) begin
      if (last_byte) begin
        for (int k = 0; k < WIN_DEPTH; k++) win_nxt[k] = '0;
        mask_nxt = '0;
      end else begin
        for (int k = 0; k < WIN_DEPTH - 1; k++) win_nxt[k] = win_r[k+1];
        win_nxt[WIN_DEPTH-1] = uri_byte;
        mask_nxt = mask_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      for (int k = 0; k < WIN_DEPTH; k++) win_r[k] <= '0;
    end else begin
      mask_r <= mask_nxt;
      win_r  <= win_nxt;
    end
  end

endmodule

// File: design/uapra_entry_cell.sv
module uapra_entry_cell import uapra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ent_req_t req,
  input  ent_ctl_t ctl,
  input  logic     free_before_i,
  output logic     free_before_o,
  output logic     hit,
  output ent_res_t res
);

  logic        valid_r;
  logic [31:0] addr_r;
  logic [7:0]  count_r;
  logic        seen_r;
  logic [31:0] stamp_r;

  logic        sel, restart, seen_b;
  logic [7:0]  base, cnt_nxt;
  logic [31:0] diff;

  assign hit           = req.valid && valid_r && (addr_r == req.addr);
  assign free_before_o = free_before_i || !valid_r;

  always_comb begin
    sel = req.valid && (hit || (!ctl.any_hit &&
          ((!valid_r && !free_before_i) || (!ctl.any_free && ctl.repl))));
    base    = hit ? count_r : 8'd0;
    seen_b  = hit && seen_r;
    diff    = req.now - stamp_r;
    restart = seen_b && (diff > {16'd0, req.rst_secs});
    cnt_nxt = restart ? 8'd0 : base;
    if (cnt_nxt != COUNT_MAX) cnt_nxt = cnt_nxt + 8'd1;
    res.count = sel ? cnt_nxt : 8'd0;
    res.alert = sel && (cnt_nxt >= req.thresh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      addr_r  <= req.addr;
      count_r <= cnt_nxt;
      seen_r  <= res.alert || seen_b;
      if (res.alert) stamp_r <= req.now;
    end
  end

endmodule

// File: design/uri_attack_pattern_rate_alert.sv
// URI attack pattern detector with per-address rate alert.
// Input channel: one URI byte per beat with source address, last-byte
// flag and seconds timestamp; accepted when in_valid is high and in_stall
// low. Bytes that are not last give no result.
// Result channel: one beat per last byte, carrying attack_found,
// attack_kind, alert and attempt_count; taken when out_valid is high and
// out_stall low.
// Throughput: one byte per cycle while in_stall is low. A last byte's
// result passes through a lookup register, then the output register.
// The address table is a row of 64 entry cells, all compared at once.
// Configuration: cfg_index selects threshold (0) or reset seconds (1);
// cfg_ready is always high. Write only while idle.
// Reset: window, match mask, table valid bits and replace pointer clear;
// threshold returns to 3 and reset seconds to 60.
// A stalled result holds; one more last byte may be accepted into the
// lookup register behind it, after which in_stall rises.
module uri_attack_pattern_rate_alert import uapra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_src_addr,
  input  logic [7:0]  in_uri_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_attack_found,
  output logic [2:0]  out_attack_kind,
  output logic        out_alert,
  output logic [7:0]  out_attempt_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  thresh_r;
  logic [15:0] rst_secs_r;

  logic        take;
  kind_t       kind;

  logic        s2_valid_r;
  kind_t       s2_kind_r;
  logic [31:0] s2_addr_r, s2_now_r;
  logic        s2_fire;

  logic        out_valid_r, out_found_r, out_alert_r;
  kind_t       out_kind_r;
  logic [7:0]  out_count_r;

  logic [PTR_W-1:0] ptr_r;
  ent_req_t         req;
  logic             free_chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] hits;
  ent_res_t         cell_res [TABLE_ENTRIES];
  ent_res_t         sel_res;
  logic             any_hit, any_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= THRESH_RST;
      rst_secs_r <= RST_SECS_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD:  thresh_r   <= cfg_data[7:0];
        REG_RESET_SECS: rst_secs_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s2_fire  = s2_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s2_valid_r && !s2_fire;
  assign take     = in_valid && !in_stall;

  uapra_matcher u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .uri_byte  (in_uri_byte),
    .last_byte (in_last_byte),
    .kind      (kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (take && in_last_byte) begin
      s2_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last_byte) begin
      s2_kind_r <= kind;
      s2_addr_r <= in_src_addr;
      s2_now_r  <= in_now_seconds;
    end
  end

  always_comb begin
    req.valid    = s2_fire && (s2_kind_r != KIND_NONE);
    req.addr     = s2_addr_r;
    req.now      = s2_now_r;
    req.thresh   = thresh_r;
    req.rst_secs = rst_secs_r;
  end

  assign free_chain[0] = 1'b0;
  assign any_hit       = |hits;
  assign any_free      = free_chain[TABLE_ENTRIES];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ent_ctl_t ctl;
    assign ctl.any_hit  = any_hit;
    assign ctl.any_free = any_free;
    assign ctl.repl     = (ptr_r == PTR_W'(i));
    uapra_entry_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .req           (req),
      .ctl           (ctl),
      .free_before_i (free_chain[i]),
      .free_before_o (free_chain[i+1]),
      .hit           (hits[i]),
      .res           (cell_res[i])
    );
  end

  always_comb begin
    sel_res = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      sel_res = sel_res | cell_res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (req.valid && !any_hit && !any_free) begin
      if (ptr_r == PTR_W'(TABLE_ENTRIES - 1)) ptr_r <= '0;
      else                                    ptr_r <= ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_found_r <= (s2_kind_r != KIND_NONE);
      out_kind_r  <= s2_kind_r;
      out_alert_r <= sel_res.alert;
      out_count_r <= sel_res.count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_attack_found  = out_found_r;
  assign out_attack_kind   = out_kind_r;
  assign out_alert         = out_alert_r;
  assign out_attempt_count = out_count_r;

endmodule

// File: design/uapra_checker.sv
`include "assert_macros.svh"

module uapra_checker import uapra_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_attack_found,
  input logic [2:0] out_attack_kind,
  input logic       out_alert,
  input logic [7:0] out_attempt_count
);

  `ASSERT_CLK_RST(a_found_kind, clk, rst_n, out_valid |-> (out_attack_found == (out_attack_kind != KIND_NONE)), "attack_found disagrees with attack_kind")
  `ASSERT_CLK_RST(a_quiet_none, clk, rst_n, (out_valid && !out_attack_found) |-> (!out_alert && out_attempt_count == 8'd0), "no attack but count or alert set")
  `ASSERT_CLK_RST(a_count_live, clk, rst_n, (out_valid && out_attack_found) |-> (out_attempt_count != 8'd0), "attack with zero count")
  `ASSERT_CLK(a_reset_idle, clk, $past(!rst_n) |-> !out_valid, "result valid just after reset")

endmodule

bind uri_attack_pattern_rate_alert uapra_checker u_uapra_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_attack_found  (out_attack_found),
  .out_attack_kind   (out_attack_kind),
  .out_alert         (out_alert),
  .out_attempt_count (out_attempt_count)
);

// File: bench/uri_attack_pattern_rate_alert_tb.sv
`timescale 1ns / 100ps

module uri_attack_pattern_rate_alert_tb;
  import uapra_pkg::*;

  typedef struct {
    logic       found;
    kind_t      kind;
    logic       alert;
    logic [7:0] count;
  } verdict_t;

  class alert_scoreboard;
    logic [7:0]  threshold;
    logic [15:0] hold_secs;
    logic [7:0]  window [WIN_DEPTH];
    logic [4:0]  seen_mask;
    logic        tab_valid [TABLE_ENTRIES];
    logic [31:0] tab_addr [TABLE_ENTRIES];
    logic [7:0]  tab_count [TABLE_ENTRIES];
    logic        tab_alerted [TABLE_ENTRIES];
    logic [31:0] tab_stamp [TABLE_ENTRIES];
    int          victim;
    verdict_t    pending[$];
    int          errors;

    function new();
      threshold = THRESH_RST;
      hold_secs = RST_SECS_RST;
      foreach (window[i]) window[i] = 8'd0;
      seen_mask = '0;
      foreach (tab_valid[i]) tab_valid[i] = 1'b0;
      victim = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] val);
      if (idx == REG_THRESHOLD) threshold = val[7:0];
      else hold_secs = val;
    endfunction

    function automatic bit ends_with(string pat, logic [7:0] cur);
      int n;
      int base;
      logic [7:0] b;
      n = pat.len();
      base = WIN_DEPTH + 1 - n;
      for (int k = 0; k < n; k++) begin
        b = (base + k == WIN_DEPTH) ? cur : window[base + k];
        if (b != pat[k]) return 0;
      end
      return 1;
    endfunction

    function automatic int find_slot(logic [31:0] a);
      int e;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (tab_valid[i] && tab_addr[i] == a) return i;
      e = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (!tab_valid[i] && e < 0) e = i;
      if (e < 0) begin
        e = victim;
        victim = (victim + 1) % TABLE_ENTRIES;
      end
      tab_valid[e] = 1'b1;
      tab_addr[e] = a;
      tab_count[e] = 8'd0;
      tab_alerted[e] = 1'b0;
      tab_stamp[e] = 32'd0;
      return e;
    endfunction

    function void note_beat(logic [31:0] a, logic [7:0] cur, logic last, logic [31:0] now);
      string pats [PAT_COUNT];
      verdict_t v;
      int e;
      pats = '{"' OR '1'='1", "<script>", "../", ";", "UNION SELECT"};
      for (int p = 0; p < PAT_COUNT; p++)
        if (ends_with(pats[p], cur)) seen_mask[p] = 1'b1;
      if (!last) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) window[i] = window[i + 1];
        window[WIN_DEPTH - 1] = cur;
        return;
      end
      v.found = 1'b0; v.kind = KIND_NONE; v.alert = 1'b0; v.count = 8'd0;
      for (int p = PAT_COUNT - 1; p >= 0; p--)
        if (seen_mask[p]) v.kind = kind_t'(p);
      foreach (window[i]) window[i] = 8'd0;
      seen_mask = '0;
      if (v.kind != KIND_NONE) begin
        v.found = 1'b1;
        e = find_slot(a);
        if (tab_alerted[e] && (now - tab_stamp[e]) > {16'd0, hold_secs}) tab_count[e] = 8'd0;
        if (tab_count[e] != COUNT_MAX) tab_count[e]++;
        v.count = tab_count[e];
        if (v.count >= threshold) begin
          v.alert = 1'b1;
          tab_alerted[e] = 1'b1;
          tab_stamp[e] = now;
        end
      end
      pending.insert(pending.size(), v);
    endfunction

    function void check_beat(logic f, logic [2:0] k, logic al, logic [7:0] c);
      verdict_t v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d", $time, k);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (f !== v.found) begin
        $display("%0t: attack_found exp %0d got %0d", $time, v.found, f); errors++;
      end
      if (k !== v.kind) begin
        $display("%0t: attack_kind exp %0d got %0d", $time, v.kind, k); errors++;
      end
      if (al !== v.alert) begin
        $display("%0t: alert exp %0d got %0d", $time, v.alert, al); errors++;
      end
      if (c !== v.count) begin
        $display("%0t: attempt_count exp %0d got %0d", $time, v.count, c); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_src_addr = '0;
  logic [7:0]  in_uri_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [31:0] in_now_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        out_attack_found;
  logic [2:0]  out_attack_kind;
  logic        out_alert;
  logic [7:0]  out_attempt_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  alert_scoreboard sb = new();
  logic [31:0] addr_pool [8];
  logic [31:0] clock_secs = 32'd1000;
  int          idle_cycles = 0;
  bit          rx_quiet = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  uri_attack_pattern_rate_alert u_top (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(out_attack_found, out_attack_kind, out_alert, out_attempt_count);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall per beat, quiet stretches
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      w = rx_quiet ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_beat(logic [31:0] a, logic [7:0] b, logic last, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_src_addr <= a;
    in_uri_byte <= b;
    in_last_byte <= last;
    in_now_seconds <= clock_secs;
    do @(posedge clk); while (in_stall);
    sb.note_beat(a, b, last, clock_secs);
    @(negedge clk);
  endtask

  task automatic send_uri(logic [31:0] a, string s, bit quiet);
    for (int i = 0; i < s.len(); i++)
      send_beat(a, s[i], i == s.len() - 1, quiet ? 0 : $urandom_range(0, 12));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic string rand_uri(logic [31:0] a);
    string frags [8];
    string s;
    int n;
    frags = '{"' OR '1'='1", "<script>", "../", ";", "UNION SELECT", "/index", "?id=", "UNION"};
    s = "/";
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) s = {s, string'(8'($urandom_range(1, 255)))};
      else s = {s, frags[$urandom_range(0, 7)]};
    end
    return s;
  endfunction

  initial begin
    int pick;
    logic [31:0] a;
    string s;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: each pattern, none, zero/ff bytes, extremes of time
    send_uri(addr_pool[0], "' OR '1'='1", 0);
    send_uri(addr_pool[0], "<script>", 0);
    send_uri(addr_pool[1], "a/../b", 0);
    send_uri(addr_pool[1], ";", 0);
    send_uri(addr_pool[0], "xUNION SELECT;", 0);
    send_uri(addr_pool[1], "ok", 0);
    send_beat(addr_pool[2], 8'h00, 1'b0, 0);
    send_beat(addr_pool[2], 8'hFF, 1'b1, 1);
    clock_secs = 32'hFFFF_FFFF;
    send_uri(addr_pool[0], ";", 1);
    clock_secs = 32'd5;
    send_uri(addr_pool[0], ";", 1);
    drain();

    write_reg(REG_THRESHOLD, 16'd1);
    write_reg(REG_RESET_SECS, 16'd0);
    for (int i = 0; i < 80; i++) begin
      clock_secs += $urandom_range(0, 1);
      send_uri($urandom, ";", $urandom_range(0, 1));
    end
    drain();

    write_reg(REG_THRESHOLD, 16'd255);
    write_reg(REG_RESET_SECS, 16'hFFFF);
    rx_quiet = 1;
    for (int i = 0; i < 300; i++) send_uri(addr_pool[3], ";", 1);
    rx_quiet = 0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_THRESHOLD, 16'($urandom_range(1, 6)));
      write_reg(REG_RESET_SECS, 16'($urandom_range(0, 40)));
      for (int i = 0; i < 32; i++) begin
        pick = $urandom_range(0, 9);
        a = (pick < 8) ? addr_pool[pick] : $urandom;
        clock_secs += $urandom_range(0, 20);
        if ($urandom_range(0, 15) == 0) clock_secs -= $urandom_range(0, 100);
        s = rand_uri(a);
        send_uri(a, s, $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 30) == 0) send_beat(a, 8'($urandom), 1'b0, 0);
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
